// File: hdl/hdlc_slarp_keepalive_engine_top_macros.svh
// assertion macros shared by the keepalive engine
`ifndef HDLC_SLARP_KEEPALIVE_ENGINE_TOP_MACROS_SVH
`define HDLC_SLARP_KEEPALIVE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSLK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keepalive engine same-cycle check failed");

// next-cycle implication, checked outside reset
`define HSLK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keepalive engine next-cycle check failed");

`endif

// File: hdl/hslk_pkg.sv
package hslk_pkg;

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_FRAME      = 2'd1,
    REQ_CONNECT    = 2'd2,
    REQ_DISCONNECT = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_SEND_KA     = 4'd1,
    ACT_SEND_REQ    = 4'd2,
    ACT_SEND_REPLY  = 4'd3,
    ACT_DELIVER     = 4'd4,
    ACT_MALFORMED   = 4'd5,
    ACT_KA_ABSORBED = 4'd6,
    ACT_REPLY_OK    = 4'd7,
    ACT_REPLY_BAD   = 4'd8,
    ACT_DISCARD     = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_LOCAL_IP = 2'd1,
    CFG_LOCAL_MASK = 2'd2
  } cfg_idx_e;

  localparam int unsigned PeriodW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PeriodW-1:0] PERIOD_DEFAULT = 15'd10;
  localparam logic [7:0]  ADDR_UNICAST   = 8'h0f;
  localparam logic [7:0]  ADDR_BROADCAST = 8'h8f;
  localparam logic [7:0]  CTRL_BYTE      = 8'h00;
  localparam logic [15:0] PROTO_SLARP    = 16'h8035;
  localparam logic [15:0] PROTO_CDP      = 16'h2000;
  localparam logic [31:0] P2P_MASK       = 32'hffff_fffc;
  localparam logic [15:0] KA_TAIL        = 16'hffff;
  localparam logic [10:0] MIN_FRAME_LEN  = 11'd4;
  localparam logic [10:0] MIN_SLARP_LEN  = 11'd18;
  localparam logic [31:0] DOWN_LIMIT_LO  = 32'd3;
  localparam logic [31:0] DOWN_LIMIT_HI  = 32'hffff_fffd;
  localparam logic [31:0] UP_LIMIT       = 32'd2;

  localparam logic [31:0] RX_CODE_REQUEST = 32'd0;
  localparam logic [31:0] RX_CODE_REPLY   = 32'd1;
  localparam logic [31:0] RX_CODE_KA      = 32'd2;
  localparam logic [1:0]  TX_CODE_REQUEST = 2'd0;
  localparam logic [1:0]  TX_CODE_REPLY   = 2'd1;
  localparam logic [1:0]  TX_CODE_KA      = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] frame_len;
    logic [7:0]  rx_address;
    logic [7:0]  rx_control;
    logic [15:0] rx_protocol;
    logic [31:0] rx_slarp_code;
    logic [31:0] rx_word_a;
    logic [31:0] rx_word_b;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  tx_slarp_code;
    logic [31:0] tx_word_a;
    logic [31:0] tx_word_b;
    logic [15:0] tx_tail;
    logic [15:0] deliver_protocol;
    logic        line_is_up;
    logic        line_changed;
    logic [31:0] peer_address;
    logic [31:0] derived_local_address;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        own_seq;
    logic [31:0]        seen_seq;
    logic [31:0]        peer_seq;
    logic               line_up;
    logic [PeriodW-1:0] sec_cnt;
    logic               link_active;
    logic [PeriodW-1:0] period;
  } ka_state_t;

endpackage

// File: hdl/hdlc_slarp_keepalive_engine_top.sv
// channel | direction | handshake                | payload
// in      | into      | in_valid_i / in_stall_o   | in_data_i  (hslk_pkg::in_item_t)
// out     | out of    | out_valid_o / out_stall_i | out_data_o (hslk_pkg::out_item_t)
// cfg     | into      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// each event passes from input transfer to result through the input register,
// then one evaluation step into the result register; one event per cycle sustained
// while out_stall_i is low; state updates but period writes in the evaluation step
// reset clears state to line down, link inactive, period 10
// out_stall_i holds a valid result register and, once the input register is full,
// raises in_stall_o in the same cycle
`include "hdlc_slarp_keepalive_engine_top_macros.svh"

module hdlc_slarp_keepalive_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  hslk_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output hslk_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [hslk_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hslk_pkg::CfgDataW-1:0]      cfg_data_i
);
  import hslk_pkg::*;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  ka_state_t state_q, state_d, state_nxt;
  out_item_t result;
  logic [31:0] local_ip_q, local_ip_d;
  logic [31:0] local_mask_q, local_mask_d;
  logic      advance;
  logic      in_xfer;

  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer = in_valid_i && !in_stall_o;

  assign in_valid_d = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  hslk_eval u_eval (
    .item_i      (in_data_q),
    .state_i     (state_q),
    .local_ip_i  (local_ip_q),
    .local_mask_i(local_mask_q),
    .state_o     (state_nxt),
    .result_o    (result)
  );

  always_comb begin
    state_d = advance ? state_nxt : state_q;
    local_ip_d = local_ip_q;
    local_mask_d = local_mask_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PERIOD: begin
          // a zero period is not taken
          if (cfg_data_i[PeriodW-1:0] != '0) begin
            state_d.period = cfg_data_i[PeriodW-1:0];
          end
        end
        CFG_LOCAL_IP: begin
          local_ip_d = cfg_data_i;
        end
        CFG_LOCAL_MASK: begin
          local_mask_d = cfg_data_i;
        end
        default: begin
          local_ip_d = local_ip_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= '{own_seq: '0, seen_seq: '0, peer_seq: '0, line_up: 1'b0,
                   sec_cnt: '0, link_active: 1'b0, period: PERIOD_DEFAULT};
      local_ip_q <= '0;
      local_mask_q <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q <= state_d;
      local_ip_q <= local_ip_d;
      local_mask_q <= local_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  // the reported line state is the state left behind by the same event
  `HSLK_ASSERT_NEXT(a_line_matches_state, clk_i, rst_ni, advance, out_data_o.line_is_up == state_q.line_up)
  // a connect always leaves an active link with cleared sequences
  `HSLK_ASSERT_NEXT(a_connect_clears, clk_i, rst_ni, advance && in_data_q.req_type == REQ_CONNECT, state_q.link_active && state_q.own_seq == '0 && state_q.seen_seq == '0)
  // the input side only stalls while holding an event it cannot pass on
  `HSLK_ASSERT_SAME(a_stall_needs_full, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q && out_stall_i)

endmodule

// File: hdl/hslk_eval.sv
module hslk_eval (
  input  hslk_pkg::in_item_t  item_i,
  input  hslk_pkg::ka_state_t state_i,
  input  logic [31:0]         local_ip_i,
  input  logic [31:0]         local_mask_i,
  output hslk_pkg::ka_state_t state_o,
  output hslk_pkg::out_item_t result_o
);
  import hslk_pkg::*;

  always_comb begin
    logic [PeriodW-1:0] sec_inc;
    logic [31:0]        own_inc;
    logic [31:0]        seq_gap;
    logic               hdr_ok;
    logic [1:0]         addr_lo;
    ka_state_t          st;
    out_item_t          res;

    st = state_i;
    res = '0;
    sec_inc = state_i.sec_cnt + PeriodW'(1);
    own_inc = state_i.own_seq + 32'd1;
    // signed distance seen as unsigned: values near the top are negative
    seq_gap = own_inc - state_i.seen_seq;
    hdr_ok = (item_i.frame_len >= MIN_FRAME_LEN)
          && ((item_i.rx_address == ADDR_UNICAST) || (item_i.rx_address == ADDR_BROADCAST))
          && (item_i.rx_control == CTRL_BYTE);
    addr_lo = item_i.rx_word_a[1:0];

    case (req_e'(item_i.req_type))
      REQ_TICK: begin
        if (state_i.link_active) begin
          if (sec_inc >= state_i.period) begin
            st.sec_cnt = '0;
            st.own_seq = own_inc;
            if (state_i.line_up && seq_gap >= DOWN_LIMIT_LO && seq_gap <= DOWN_LIMIT_HI) begin
              st.line_up = 1'b0;
              res.line_changed = 1'b1;
            end else if (!state_i.line_up && seq_gap <= UP_LIMIT) begin
              st.line_up = 1'b1;
              res.line_changed = 1'b1;
            end
            res.action = ACT_SEND_KA;
            res.tx_slarp_code = TX_CODE_KA;
            res.tx_word_a = own_inc;
            res.tx_word_b = state_i.peer_seq;
            res.tx_tail = KA_TAIL;
          end else begin
            st.sec_cnt = sec_inc;
          end
        end
      end
      REQ_CONNECT: begin
        st.own_seq = '0;
        st.seen_seq = '0;
        st.peer_seq = '0;
        res.line_changed = state_i.line_up;
        st.line_up = 1'b0;
        st.period = PERIOD_DEFAULT;
        st.sec_cnt = '0;
        st.link_active = 1'b1;
        res.action = ACT_SEND_REQ;
        res.tx_slarp_code = TX_CODE_REQUEST;
      end
      REQ_DISCONNECT: begin
        st.link_active = 1'b0;
        st.sec_cnt = '0;
      end
      REQ_FRAME: begin
        if (!hdr_ok) begin
          res.action = ACT_MALFORMED;
        end else if (item_i.rx_protocol == PROTO_SLARP) begin
          if (item_i.frame_len < MIN_SLARP_LEN) begin
            res.action = ACT_MALFORMED;
          end else if (item_i.rx_slarp_code == RX_CODE_REQUEST) begin
            st.peer_seq = '0;
            res.action = ACT_SEND_REPLY;
            res.tx_slarp_code = TX_CODE_REPLY;
            res.tx_word_a = local_ip_i;
            res.tx_word_b = local_mask_i;
          end else if (item_i.rx_slarp_code == RX_CODE_REPLY) begin
            // low address bits must name one end of a /30
            if (item_i.rx_word_b == P2P_MASK && addr_lo != 2'b00 && addr_lo != 2'b11) begin
              res.action = ACT_REPLY_OK;
              res.peer_address = item_i.rx_word_a;
              res.derived_local_address = item_i.rx_word_a ^ 32'd3;
            end else begin
              res.action = ACT_REPLY_BAD;
            end
          end else if (item_i.rx_slarp_code == RX_CODE_KA) begin
            st.peer_seq = item_i.rx_word_a;
            st.seen_seq = item_i.rx_word_b;
            res.action = ACT_KA_ABSORBED;
          end else begin
            res.action = ACT_DISCARD;
          end
        end else if (item_i.rx_protocol == PROTO_CDP) begin
          res.action = ACT_DISCARD;
        end else begin
          res.action = ACT_DELIVER;
          res.deliver_protocol = item_i.rx_protocol;
        end
      end
      default: begin
        res.action = ACT_NONE;
      end
    endcase

    res.line_is_up = st.line_up;
    state_o = st;
    result_o = res;
  end

endmodule

// File: tb/sv/hdlc_slarp_keepalive_engine_monitor.sv
module hdlc_slarp_keepalive_engine_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  hslk_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  hslk_pkg::out_item_t           out_data_i,
  input  logic                          cfg_we_i,
  input  logic [hslk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hslk_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_count_o
);
  import hslk_pkg::*;

  logic [PeriodW-1:0] period;
  logic [31:0]        local_ip;
  logic [31:0]        local_mask;
  logic [31:0]        own_seq;
  logic [31:0]        seen_seq;
  logic [31:0]        peer_seq;
  logic [PeriodW-1:0] sec_cnt;
  logic               line_up;
  logic               link_active;

  out_item_t expected_outcomes[$];

  function automatic string outcome_text(input out_item_t r);
    return $sformatf("act=%0d code=%0d a=%h b=%h tail=%h proto=%h up=%b chg=%b peer=%h derived=%h",
                     r.action, r.tx_slarp_code, r.tx_word_a, r.tx_word_b, r.tx_tail,
                     r.deliver_protocol, r.line_is_up, r.line_changed, r.peer_address,
                     r.derived_local_address);
  endfunction

  // advances the link state by one event and returns the result it gives
  function automatic out_item_t predict_event_outcome(input in_item_t ev);
    out_item_t   r;
    logic [31:0] seq_gap;
    r = '0;
    case (ev.req_type)
      REQ_TICK: begin
        if (link_active) begin
          sec_cnt = sec_cnt + 15'd1;
          if (sec_cnt >= period) begin
            sec_cnt = '0;
            own_seq = own_seq + 32'd1;
            seq_gap = own_seq - seen_seq;
            // signed distance: down beyond +-2, up within 0..2
            if (line_up && seq_gap >= DOWN_LIMIT_LO && seq_gap <= DOWN_LIMIT_HI) begin
              line_up = 1'b0;
              r.line_changed = 1'b1;
            end else if (!line_up && seq_gap <= UP_LIMIT) begin
              line_up = 1'b1;
              r.line_changed = 1'b1;
            end
            r.action        = ACT_SEND_KA;
            r.tx_slarp_code = TX_CODE_KA;
            r.tx_word_a     = own_seq;
            r.tx_word_b     = peer_seq;
            r.tx_tail       = KA_TAIL;
          end
        end
      end
      REQ_CONNECT: begin
        own_seq  = '0;
        seen_seq = '0;
        peer_seq = '0;
        r.line_changed = line_up;
        line_up     = 1'b0;
        period      = PERIOD_DEFAULT;
        sec_cnt     = '0;
        link_active = 1'b1;
        r.action        = ACT_SEND_REQ;
        r.tx_slarp_code = TX_CODE_REQUEST;
      end
      REQ_DISCONNECT: begin
        link_active = 1'b0;
        sec_cnt     = '0;
      end
      default: begin
        if (ev.frame_len < MIN_FRAME_LEN || ev.rx_control != CTRL_BYTE ||
            (ev.rx_address != ADDR_UNICAST && ev.rx_address != ADDR_BROADCAST)) begin
          r.action = ACT_MALFORMED;
        end else if (ev.rx_protocol == PROTO_SLARP) begin
          if (ev.frame_len < MIN_SLARP_LEN) begin
            r.action = ACT_MALFORMED;
          end else if (ev.rx_slarp_code == RX_CODE_REQUEST) begin
            peer_seq        = '0;
            r.action        = ACT_SEND_REPLY;
            r.tx_slarp_code = TX_CODE_REPLY;
            r.tx_word_a     = local_ip;
            r.tx_word_b     = local_mask;
          end else if (ev.rx_slarp_code == RX_CODE_REPLY) begin
            // low two address bits must be 01 or 10
            if (ev.rx_word_b == P2P_MASK && ev.rx_word_a[1] != ev.rx_word_a[0]) begin
              r.action                = ACT_REPLY_OK;
              r.peer_address          = ev.rx_word_a;
              r.derived_local_address = {ev.rx_word_a[31:2], ~ev.rx_word_a[1:0]};
            end else begin
              r.action = ACT_REPLY_BAD;
            end
          end else if (ev.rx_slarp_code == RX_CODE_KA) begin
            peer_seq = ev.rx_word_a;
            seen_seq = ev.rx_word_b;
            r.action = ACT_KA_ABSORBED;
          end else begin
            r.action = ACT_DISCARD;
          end
        end else if (ev.rx_protocol == PROTO_CDP) begin
          r.action = ACT_DISCARD;
        end else begin
          r.action           = ACT_DELIVER;
          r.deliver_protocol = ev.rx_protocol;
        end
      end
    endcase
    r.line_is_up = line_up;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      period      = PERIOD_DEFAULT;
      local_ip    = '0;
      local_mask  = '0;
      own_seq     = '0;
      seen_seq    = '0;
      peer_seq    = '0;
      sec_cnt     = '0;
      line_up     = 1'b0;
      link_active = 1'b0;
      expected_outcomes.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected result transfer: %s", $time, outcome_text(out_data_i));
          mismatch_count_o++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data_i.action !== want.action ||
              out_data_i.tx_slarp_code !== want.tx_slarp_code ||
              out_data_i.tx_word_a !== want.tx_word_a ||
              out_data_i.tx_word_b !== want.tx_word_b ||
              out_data_i.tx_tail !== want.tx_tail ||
              out_data_i.deliver_protocol !== want.deliver_protocol ||
              out_data_i.line_is_up !== want.line_is_up ||
              out_data_i.line_changed !== want.line_changed ||
              out_data_i.peer_address !== want.peer_address ||
              out_data_i.derived_local_address !== want.derived_local_address) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: result differs", $time);
              $display("  expected %s", outcome_text(want));
              $display("  actual   %s", outcome_text(out_data_i));
            end
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PERIOD: begin
            // a zero period is not taken
            if (cfg_data_i[PeriodW-1:0] != '0)
              period = cfg_data_i[PeriodW-1:0];
          end
          CFG_LOCAL_IP:   local_ip = cfg_data_i;
          CFG_LOCAL_MASK: local_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_outcomes.push_back(predict_event_outcome(in_data_i));
      pending_count_o = expected_outcomes.size();
    end
  end

endmodule

// File: tb/sv/hdlc_slarp_keepalive_engine_top_test.sv
module hdlc_slarp_keepalive_engine_top_test;
  import hslk_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 150;
  localparam int Phases        = 8;
  localparam int PhaseItems    = 125;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_PERIOD;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int quiet_cycles = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  bit long_hold_req = 1'b0;

  logic [31:0] period_picks [Phases] = '{32'd1, 32'd2, 32'h0000_7fff, 32'd0,
                                          32'd3, 32'd1, 32'hffff_8005, 32'd4};

  hdlc_slarp_keepalive_engine_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hdlc_slarp_keepalive_engine_monitor i_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("hdlc_slarp_keepalive_engine_top: mismatch");
        $finish;
      end
    end
  end

  function automatic in_item_t noise_frame();
    in_item_t ev;
    ev.req_type      = REQ_FRAME;
    ev.frame_len     = 11'($urandom);
    ev.rx_address    = 8'($urandom);
    ev.rx_control    = 8'($urandom);
    ev.rx_protocol   = 16'($urandom);
    ev.rx_slarp_code = $urandom;
    ev.rx_word_a     = $urandom;
    ev.rx_word_b     = $urandom;
    return ev;
  endfunction

  function automatic in_item_t bare_event(input req_e kind);
    in_item_t ev;
    ev = noise_frame();
    ev.req_type = kind;
    return ev;
  endfunction

  function automatic in_item_t slarp_frame(input logic [31:0] code, input logic [31:0] wa,
                                           input logic [31:0] wb);
    in_item_t ev;
    ev.req_type      = REQ_FRAME;
    ev.frame_len     = MIN_SLARP_LEN;
    ev.rx_address    = ADDR_UNICAST;
    ev.rx_control    = CTRL_BYTE;
    ev.rx_protocol   = PROTO_SLARP;
    ev.rx_slarp_code = code;
    ev.rx_word_a     = wa;
    ev.rx_word_b     = wb;
    return ev;
  endfunction

  // mostly ticks and well-formed slarp traffic, some raw noise frames
  function automatic in_item_t random_event();
    in_item_t    ev;
    int unsigned pick;
    int unsigned kind;
    ev = noise_frame();
    pick = $urandom_range(99);
    if (pick < 45) begin
      ev.req_type = REQ_TICK;
    end else if (pick < 48) begin
      ev.req_type = REQ_CONNECT;
    end else if (pick < 49) begin
      ev.req_type = REQ_DISCONNECT;
    end else if (pick < 85) begin
      ev.rx_address  = $urandom_range(1) ? ADDR_UNICAST : ADDR_BROADCAST;
      ev.rx_control  = CTRL_BYTE;
      ev.frame_len   = ($urandom_range(3) == 0) ? MIN_SLARP_LEN : 11'($urandom_range(2047, 18));
      ev.rx_protocol = PROTO_SLARP;
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: begin
          ev.rx_slarp_code = RX_CODE_KA;
          // keep the seen sequence near our own so the line moves both ways
          if ($urandom_range(7) != 0)
            ev.rx_word_b = $urandom_range(40);
        end
        4: ev.rx_slarp_code = RX_CODE_REQUEST;
        5, 6: begin
          ev.rx_slarp_code = RX_CODE_REPLY;
          if ($urandom_range(3) != 0)
            ev.rx_word_b = P2P_MASK;
        end
        7: ev.rx_protocol = $urandom_range(1) ? PROTO_CDP : 16'($urandom);
        8: ev.rx_slarp_code = $urandom_range(1) ? 32'd3 : $urandom;
        default: ev.frame_len = 11'($urandom_range(17));
      endcase
    end
    return ev;
  endfunction

  task automatic offer_event(input in_item_t ev);
    int gap;
    gap = in_gaps_on ? $urandom_range(8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stall before each transfer, one long hold-off on request
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else begin
        hold = out_gaps_on ? $urandom_range(8) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    in_item_t ev;
    int       phase;
    int       k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer_event(bare_event(REQ_CONNECT));
    drain();
    write_reg(CFG_PERIOD, 32'd2);
    write_reg(CFG_LOCAL_IP, 32'hc0a8_0a01);
    write_reg(CFG_LOCAL_MASK, P2P_MASK);

    ev = slarp_frame(RX_CODE_KA, '0, '0);
    ev.frame_len = '0;
    offer_event(ev);
    ev = slarp_frame(RX_CODE_KA, '0, '0);
    ev.rx_address = 8'h00;
    offer_event(ev);
    ev = slarp_frame(RX_CODE_KA, '0, '0);
    ev.rx_control = 8'hff;
    offer_event(ev);
    ev = slarp_frame(RX_CODE_REQUEST, '0, '0);
    ev.frame_len = MIN_SLARP_LEN - 11'd1;
    offer_event(ev);
    ev = slarp_frame(RX_CODE_KA, '1, '1);
    ev.rx_protocol = PROTO_CDP;
    offer_event(ev);
    offer_event(slarp_frame(32'hffff_ffff, '1, '1));
    ev = slarp_frame(RX_CODE_REQUEST, '1, '1);
    ev.rx_protocol = 16'hffff;
    ev.frame_len   = 11'h7ff;
    ev.rx_address  = ADDR_BROADCAST;
    offer_event(ev);
    offer_event(slarp_frame(RX_CODE_REQUEST, '0, '0));
    // reply checks on the low address bits and the mask
    offer_event(slarp_frame(RX_CODE_REPLY, 32'h0a00_0001, P2P_MASK));
    offer_event(slarp_frame(RX_CODE_REPLY, 32'hffff_fffe, P2P_MASK));
    offer_event(slarp_frame(RX_CODE_REPLY, 32'h0a00_0000, P2P_MASK));
    offer_event(slarp_frame(RX_CODE_REPLY, 32'h0a00_0003, P2P_MASK));
    offer_event(slarp_frame(RX_CODE_REPLY, 32'h0a00_0001, '1));
    // line up, then down on a distance of -3, then up again
    offer_event(bare_event(REQ_TICK));
    offer_event(bare_event(REQ_TICK));
    offer_event(slarp_frame(RX_CODE_KA, '1, 32'd5));
    offer_event(bare_event(REQ_TICK));
    offer_event(bare_event(REQ_TICK));
    offer_event(slarp_frame(RX_CODE_KA, '0, 32'd2));
    offer_event(bare_event(REQ_TICK));
    offer_event(bare_event(REQ_TICK));
    offer_event(bare_event(REQ_DISCONNECT));
    offer_event(bare_event(REQ_TICK));
    offer_event(bare_event(REQ_CONNECT));

    for (phase = 0; phase < Phases; phase++) begin
      in_gaps_on  = (phase % 3) != 1;
      out_gaps_on = (phase % 4) != 2;
      offer_event(bare_event(REQ_CONNECT));
      drain();
      if (period_picks[phase] == '0)
        write_reg(CFG_PERIOD, 32'd3);
      write_reg(CFG_PERIOD, period_picks[phase]);
      if (phase == 0) begin
        write_reg(CFG_LOCAL_IP, '0);
        write_reg(CFG_LOCAL_MASK, '0);
      end else if (phase == 1) begin
        write_reg(CFG_LOCAL_IP, '1);
        write_reg(CFG_LOCAL_MASK, '1);
      end else begin
        write_reg(CFG_LOCAL_IP, $urandom);
        write_reg(CFG_LOCAL_MASK, $urandom);
      end
      for (k = 0; k < PhaseItems; k++) begin
        if (phase == 4 && k == 20)
          long_hold_req = 1'b1;
        if (k == 60)
          drain();
        offer_event(random_event());
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("hdlc_slarp_keepalive_engine_top: match");
    else
      $display("hdlc_slarp_keepalive_engine_top: mismatch");
    $finish;
  end

endmodule

// File: hdlc_slarp_keepalive_engine_top.f
+incdir+hdl
hdl/hslk_pkg.sv
hdl/hslk_eval.sv
hdl/hdlc_slarp_keepalive_engine_top.sv
tb/sv/hdlc_slarp_keepalive_engine_monitor.sv
tb/sv/hdlc_slarp_keepalive_engine_top_test.sv
